FILE: hw/rtl/mts_pkg.sv
// Shared types and constants for the melody tone sequencer.
package mts_pkg;

    localparam int TIME_W    = 20;
    localparam int BEAT_W    = 16;
    localparam int PERIOD_W  = 16;
    localparam int DIV_NUM_W = 18;
    localparam int DIV_DEN_W = 10;

    localparam logic [DIV_NUM_W-1:0] TEMPO_NUM = DIV_NUM_W'(60000);

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_NOTE   = 2'd2;
    localparam logic [1:0] KIND_SINGLE = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [9:0]        bpm;
        logic [15:0]       note_period;
        logic signed [7:0] note_length;
        logic [14:0]       play_ms;
        logic              last_note;
        logic              muted;
    } mts_in_t;

    typedef struct packed {
        logic        tone_enable;
        logic [15:0] pwm_top;
        logic [14:0] pwm_compare;
        logic        note_sounding;
        logic        sequence_running;
        logic        rejected;
    } mts_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_EMIT
    } mts_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic div_start;
        logic div_apply;
        logic load_out;
    } mts_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       note_reject;
        logic       div_done;
        logic       out_free;
    } mts_status_t;

endpackage

FILE: hw/rtl/mts_div.sv
// Restoring divider, one quotient bit per cycle.
module mts_div
    import mts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_NUM_W - 1);

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   rem_shift;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 fits;
    logic [DIV_DEN_W-1:0] rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_NUM_W-1]};
        rem_sub   = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};
        rem_next  = fits ? rem_sub[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/mts_datapath.sv
// Sequencer state, divider operand selection and result register.
module mts_datapath
    import mts_pkg::*;
#(
    parameter int TICK_MS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  mts_in_t     in_data,
    input  mts_cmd_t    cmd,
    output mts_status_t sts,
    input  logic        out_ready,
    output logic        out_valid,
    output mts_out_t    out_data
);

    mts_in_t              item_reg;
    logic [BEAT_W-1:0]    beat_reg;
    logic [TIME_W-1:0]    remain_reg;
    logic                 note_reg;
    logic                 seq_reg;
    logic                 ends_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic                 rej_reg;
    logic                 out_valid_reg;
    mts_out_t             out_data_reg;

    logic                 dotted;
    logic [7:0]           mag;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic [TIME_W-1:0]    note_time;
    logic [TIME_W-1:0]    tick_time;

    always_comb
    begin
        dotted = item_reg.note_length[7];
        // two's complement of 0x80 stays 0x80, which is the magnitude wanted
        mag    = dotted ? 8'(-item_reg.note_length) : item_reg.note_length;
        if (item_reg.kind == KIND_START)
        begin
            div_num = TEMPO_NUM;
            div_den = (item_reg.bpm == '0) ? DIV_DEN_W'(1) : item_reg.bpm;
        end
        else
        begin
            div_num = {beat_reg, 2'b00};
            div_den = {2'b00, mag};
        end
        // floor(x / 2m) == floor(floor(x / m) / 2)
        note_time = dotted ? (TIME_W'(div_quo) + TIME_W'(div_quo >> 1)) : TIME_W'(div_quo);
        tick_time = TIME_W'(TICK_MS);
    end

    mts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg   <= '0;
            remain_reg <= '0;
            note_reg   <= 1'b0;
            seq_reg    <= 1'b0;
            ends_reg   <= 1'b0;
            period_reg <= '0;
            rej_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                rej_reg <= 1'b0;
            end
            if (cmd.exec)
            begin
                case (item_reg.kind)
                    KIND_TICK:
                    begin
                        if (note_reg)
                        begin
                            if (remain_reg <= tick_time)
                            begin
                                remain_reg <= '0;
                                note_reg   <= 1'b0;
                                if (ends_reg && seq_reg)
                                begin
                                    seq_reg  <= 1'b0;
                                    ends_reg <= 1'b0;
                                end
                            end
                            else
                            begin
                                remain_reg <= remain_reg - tick_time;
                            end
                        end
                    end
                    KIND_SINGLE:
                    begin
                        period_reg <= item_reg.note_period;
                        remain_reg <= TIME_W'(item_reg.play_ms);
                        note_reg   <= 1'b1;
                    end
                    KIND_NOTE:
                    begin
                        rej_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.div_apply)
            begin
                if (item_reg.kind == KIND_START)
                begin
                    beat_reg <= div_quo[BEAT_W-1:0];
                    seq_reg  <= 1'b1;
                    ends_reg <= 1'b0;
                end
                else
                begin
                    remain_reg <= note_time;
                    period_reg <= item_reg.note_period;
                    ends_reg   <= item_reg.last_note;
                    note_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (cmd.load_out)
        begin
            out_data_reg.tone_enable      <= note_reg && !item_reg.muted;
            out_data_reg.pwm_top          <= period_reg;
            out_data_reg.pwm_compare      <= period_reg[PERIOD_W-1:1];
            out_data_reg.note_sounding    <= note_reg;
            out_data_reg.sequence_running <= seq_reg;
            out_data_reg.rejected         <= rej_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.load_out || (out_valid_reg && !out_ready);
        end
    end

    always_comb
    begin
        sts.kind        = item_reg.kind;
        sts.note_reject = (item_reg.note_length == '0) || !seq_reg || note_reg;
        sts.div_done    = div_done;
        sts.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hw/rtl/mts_ctrl.sv
// Control state machine: capture, decode, divide, emit.
module mts_ctrl
    import mts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mts_status_t sts,
    output mts_cmd_t    cmd
);

    mts_state_t state_reg;
    mts_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                // ticks, single notes and refused notes are executed directly, without the divider
                if ((sts.kind inside {KIND_TICK, KIND_SINGLE}) ||
                    (sts.kind == KIND_NOTE && sts.note_reject))
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_apply = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/melody_tone_sequencer.sv
// Melody tone sequencer: top level joining the controller and the datapath.
// One result per input item. Tick items, single timed notes and refused sequence
// notes go from the input transfer through decode and emit to a waiting result;
// start items and accepted sequence notes also pass the shared restoring divider,
// which produces one of its 18 quotient bits per cycle (tempo 60000/bpm and note time
// beat*4/|d|, the dotted half taken from the same quotient). The block takes one
// item at a time; a new item is taken while the previous result still waits in the
// output register. TICK_MS (1..1000) is the time in ms that one tick item subtracts.
module melody_tone_sequencer
    import mts_pkg::*;
#(
    parameter int TICK_MS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  mts_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output mts_out_t out_data
);

    mts_cmd_t    cmd;
    mts_status_t sts;

    mts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mts_datapath #(
        .TICK_MS (TICK_MS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

FILE: hw/rtl/mts_checker.sv
// Port-level checks for the melody tone sequencer and their bind.
module mts_checker
    import mts_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input mts_in_t  in_data,
    input logic     out_valid,
    input logic     out_ready,
    input mts_out_t out_data
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_xfer;
    logic       out_xfer;

    always_comb
    begin
        in_xfer   = in_valid && in_ready;
        out_xfer  = out_valid && out_ready;
        pend_next = pend_reg + (in_xfer ? 2'd1 : 2'd0) - (out_xfer ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again before the item was processed");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result shown with no item outstanding");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many items outstanding");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> pend_reg != 2'd2)
        else $error("input ready while both result slot and work slot are full");

endmodule

bind melody_tone_sequencer mts_checker u_mts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
